// ===== design/ptm_pkg.sv =====
// Shared constants, operation codes and controller/datapath interface types.
package ptm_pkg;

	localparam int PHASES_DEF         = 4;
	localparam int AVG_FRAC_BITS_DEF  = 8;
	localparam int AVG_SHIFT_BITS_DEF = 3;

	localparam int OP_W    = 2;
	localparam int PHASE_W = 2;
	localparam int TS_W    = 32;
	localparam int MISS_W  = 16;

	localparam logic [MISS_W-1:0] MISS_MAX = 16'hFFFF;

	localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
	localparam logic [OP_W-1:0] OP_END   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

	typedef struct packed {
		logic cap;
		logic elap;
		logic diff;
		logic avg;
		logic jit;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            ok;
	} sts_t;

endpackage

// ===== design/phase_timing_monitor_top.sv =====
// Top level of the per-phase execution timing monitor.
// Each transfer in is a begin, end, clear or query event for one phase and yields one
// transfer out with that phase's statistics after the event. Events are handled one at
// a time by a sequencer over a shared datapath: begin, clear and query step through
// capture, elapsed, then the result register; an end on a valid phase also steps through
// difference, average and jitter before it. The result register lets a new event be taken
// while the previous result still waits. Phases at or above PHASES report zero statistics.
module phase_timing_monitor_top #(
	parameter int PHASES         = ptm_pkg::PHASES_DEF,
	parameter int AVG_FRAC_BITS  = ptm_pkg::AVG_FRAC_BITS_DEF,
	parameter int AVG_SHIFT_BITS = ptm_pkg::AVG_SHIFT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [ptm_pkg::OP_W-1:0]     op,
	input  logic [ptm_pkg::PHASE_W-1:0]  phase,
	input  logic [ptm_pkg::TS_W-1:0]     timestamp_us,
	input  logic [ptm_pkg::TS_W-1:0]     budget_us,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ptm_pkg::TS_W-1:0]     max_us,
	output logic [ptm_pkg::TS_W-1:0]     avg_us,
	output logic [ptm_pkg::TS_W-1:0]     max_jitter_us,
	output logic [ptm_pkg::MISS_W-1:0]   deadline_misses,
	output logic                         exceeded,
	output logic                         all_within_budget
);
	import ptm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ptm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ptm_dp #(
		.PHASES         (PHASES),
		.AVG_FRAC_BITS  (AVG_FRAC_BITS),
		.AVG_SHIFT_BITS (AVG_SHIFT_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.op                (op),
		.phase             (phase),
		.timestamp_us      (timestamp_us),
		.budget_us         (budget_us),
		.max_us            (max_us),
		.avg_us            (avg_us),
		.max_jitter_us     (max_jitter_us),
		.deadline_misses   (deadline_misses),
		.exceeded          (exceeded),
		.all_within_budget (all_within_budget)
	);

	a_one_event_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second event taken while one in flight");

	a_exceeded_clears_all_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && exceeded) |-> !all_within_budget)
		else $error("overrun phase reported with all phases in budget");

	a_miss_implies_exceeded: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && deadline_misses != '0) |-> exceeded)
		else $error("misses counted without overrun flag");

	a_avg_not_above_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (avg_us <= max_us))
		else $error("average above largest elapsed time");

endmodule

// ===== design/ptm_ctrl.sv =====
// Sequencer for the monitor: steps one event through the datapath and owns the handshakes.
module ptm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ptm_pkg::sts_t sts,
	output ptm_pkg::cmd_t cmd
);
	import ptm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ELAP = 3'd1;
	localparam logic [2:0] ST_DIFF = 3'd2;
	localparam logic [2:0] ST_AVG  = 3'd3;
	localparam logic [2:0] ST_JIT  = 3'd4;
	localparam logic [2:0] ST_RESP = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_ELAP;
				end
			end
			ST_ELAP: begin
				cmd.elap = 1'b1;
				if (sts.op == OP_END && sts.ok) begin
					state_d = ST_DIFF;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_AVG;
			end
			ST_AVG: begin
				cmd.avg = 1'b1;
				state_d = ST_JIT;
			end
			ST_JIT: begin
				cmd.jit = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (slot_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/ptm_dp.sv =====
// Datapath: per-phase statistics store, elapsed/average/jitter arithmetic and result register.
module ptm_dp #(
	parameter int PHASES         = ptm_pkg::PHASES_DEF,
	parameter int AVG_FRAC_BITS  = ptm_pkg::AVG_FRAC_BITS_DEF,
	parameter int AVG_SHIFT_BITS = ptm_pkg::AVG_SHIFT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ptm_pkg::cmd_t                cmd,
	output ptm_pkg::sts_t                sts,
	input  logic [ptm_pkg::OP_W-1:0]     op,
	input  logic [ptm_pkg::PHASE_W-1:0]  phase,
	input  logic [ptm_pkg::TS_W-1:0]     timestamp_us,
	input  logic [ptm_pkg::TS_W-1:0]     budget_us,
	output logic [ptm_pkg::TS_W-1:0]     max_us,
	output logic [ptm_pkg::TS_W-1:0]     avg_us,
	output logic [ptm_pkg::TS_W-1:0]     max_jitter_us,
	output logic [ptm_pkg::MISS_W-1:0]   deadline_misses,
	output logic                         exceeded,
	output logic                         all_within_budget
);
	import ptm_pkg::*;

	localparam int IDX_W = (PHASES > 1) ? $clog2(PHASES) : 1;
	localparam int AVG_W = TS_W + AVG_FRAC_BITS;

	logic [OP_W-1:0]    op_q;
	logic [PHASE_W-1:0] phase_q;
	logic [TS_W-1:0]    ts_q;
	logic [TS_W-1:0]    budget_q;
	logic [TS_W-1:0]    elapsed_q;
	logic signed [AVG_W:0] diff_q;
	logic [AVG_W-1:0]   avg_new_q;

	logic [TS_W-1:0]   start_q  [PHASES];
	logic [TS_W-1:0]   max_q    [PHASES];
	logic [AVG_W-1:0]  avg_q    [PHASES];
	logic              avgv_q   [PHASES];
	logic [TS_W-1:0]   jit_q    [PHASES];
	logic [MISS_W-1:0] miss_q   [PHASES];
	logic [PHASES-1:0] ovr_q;

	logic [IDX_W-1:0]      idx;
	logic                  ok;
	logic [AVG_W-1:0]      sample;
	logic signed [AVG_W:0] avg_sum;
	logic [AVG_W-1:0]      avg_next;
	logic [TS_W-1:0]       avg_new_us;
	logic [TS_W-1:0]       jit;

	assign idx        = IDX_W'(phase_q);
	assign ok         = int'(phase_q) < PHASES;
	assign sts.op     = op_q;
	assign sts.ok     = ok;
	assign sample     = AVG_W'(elapsed_q) << AVG_FRAC_BITS;
	assign avg_sum    = $signed({1'b0, avg_q[idx]}) + (diff_q >>> AVG_SHIFT_BITS);
	assign avg_next   = avgv_q[idx] ? avg_sum[AVG_W-1:0] : sample;
	assign avg_new_us = TS_W'(avg_new_q >> AVG_FRAC_BITS);
	assign jit        = (elapsed_q > avg_new_us) ? (elapsed_q - avg_new_us)
	                                             : (avg_new_us - elapsed_q);

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q     <= op;
			phase_q  <= phase;
			ts_q     <= timestamp_us;
			budget_q <= budget_us;
		end
		if (cmd.elap) begin
			elapsed_q <= ts_q - start_q[idx];
		end
		if (cmd.diff) begin
			diff_q <= $signed({1'b0, sample}) - $signed({1'b0, avg_q[idx]});
		end
		if (cmd.avg) begin
			avg_new_q <= avg_next;
		end
		if (cmd.load_out) begin
			max_us            <= ok ? max_q[idx] : '0;
			avg_us            <= ok ? TS_W'(avg_q[idx] >> AVG_FRAC_BITS) : '0;
			max_jitter_us     <= ok ? jit_q[idx] : '0;
			deadline_misses   <= ok ? miss_q[idx] : '0;
			exceeded          <= ok ? ovr_q[idx] : 1'b0;
			all_within_budget <= ~|ovr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PHASES; i++) begin
				start_q[i] <= '0;
				max_q[i]   <= '0;
				avg_q[i]   <= '0;
				avgv_q[i]  <= 1'b0;
				jit_q[i]   <= '0;
				miss_q[i]  <= '0;
			end
			ovr_q <= '0;
		end else if (cmd.elap && op_q == OP_CLEAR) begin
			for (int i = 0; i < PHASES; i++) begin
				start_q[i] <= '0;
				max_q[i]   <= '0;
				avg_q[i]   <= '0;
				avgv_q[i]  <= 1'b0;
				jit_q[i]   <= '0;
				miss_q[i]  <= '0;
			end
			ovr_q <= '0;
		end else begin
			if (cmd.elap && op_q == OP_BEGIN && ok) begin
				start_q[idx] <= ts_q;
			end
			if (cmd.diff) begin
				if (elapsed_q > max_q[idx]) begin
					max_q[idx] <= elapsed_q;
				end
				if (elapsed_q > budget_q) begin
					ovr_q[idx] <= 1'b1;
					if (miss_q[idx] != MISS_MAX) begin
						miss_q[idx] <= miss_q[idx] + MISS_W'(1);
					end
				end
			end
			if (cmd.avg) begin
				avg_q[idx]  <= avg_next;
				avgv_q[idx] <= 1'b1;
			end
			if (cmd.jit && jit > jit_q[idx]) begin
				jit_q[idx] <= jit;
			end
		end
	end

endmodule
